### rtl/olb_pkg.sv
// shared types and constants for the line break engine
`timescale 1ns / 1ps
package olb_pkg;

  // field widths
  localparam int WW        = 12;   // word width field
  localparam int SPW       = 12;   // space field
  localparam int MARK_W    = 4;
  localparam int CFG_W     = 12;
  localparam int PREV_W    = 14;
  localparam int COL_W     = 14;
  localparam int IDX_OUT_W = 11;
  localparam int COST_OUT_W = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 14;

  // internal arithmetic widths
  localparam int WID_W  = 16;      // running line width
  localparam int DIFF_W = 17;      // signed width difference
  localparam int TEN_W  = 21;      // difference times ten
  localparam int SQ_W   = 40;      // square of that
  localparam int FIT_W  = 41;
  localparam int FIX_W  = 21;      // per-line fixed cost
  localparam int DIV_W  = 16;      // divider numerator and quotient
  localparam int DEN_W  = 13;      // divider denominator

  // mark bit positions
  localparam int MK_PAREN  = 0;
  localparam int MK_PERIOD = 1;
  localparam int MK_PUNCT  = 2;
  localparam int MK_FINAL  = 3;

  // cost constants
  localparam int C_LINE     = 4900;
  localparam int C_WIDOW    = 40000;
  localparam int C_ORPHAN   = 22500;
  localparam int C_SENTENCE = 2500;
  localparam int C_NOBREAK  = 360000;
  localparam int C_PAREN    = 1600;
  localparam int C_PUNCT    = 1600;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_SUMMARY = 2'd0;
  localparam logic [1:0] STAT_LINE    = 2'd1;
  localparam logic [1:0] STAT_REJECT  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_IND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OTHER_IND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PREV_WIDTH = 3'd4;

  typedef struct packed {
    logic [MARK_W-1:0] mark;
    logic [SPW-1:0]    space;
    logic [WW-1:0]     width;
  } word_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [IDX_OUT_W-1:0]  line_start;
    logic [IDX_OUT_W-1:0]  line_end;
    logic [COL_W-1:0]      line_columns;
    logic [IDX_OUT_W-1:0]  line_total;
    logic [COST_OUT_W-1:0] total_cost;
    logic                  final_line;
  } res_t;

endpackage

### rtl/olb_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module olb_div
  import olb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             busy,
  output logic [DIV_W-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   trial;

  assign trial = {rem, quot[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
      den  <= req.den;
      quot <= req.num;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
      end
      if (trial >= {1'b0, den}) begin
        rem  <= DEN_W'(trial - {1'b0, den});
        quot <= {quot[DIV_W-2:0], 1'b1};
      end else begin
        rem  <= trial[DEN_W-1:0];
        quot <= {quot[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/olb_sq.sv
// registered square of ten times a signed width difference
`timescale 1ns / 1ps
module olb_sq
  import olb_pkg::*;
(
  input  logic                     clk,
  input  logic signed [DIFF_W-1:0] d,
  output logic [SQ_W-1:0]          sq
);

  logic signed [TEN_W-1:0] t;
  logic [TEN_W-2:0]        mag;

  always_comb begin
    t   = (TEN_W'(d) <<< 3) + (TEN_W'(d) <<< 1);
    mag = t[TEN_W-1] ? (TEN_W-1)'(-t) : t[TEN_W-2:0];
  end

  always_ff @(posedge clk) begin
    sq <= mag * mag;
  end

endmodule

### rtl/optimal_line_break_dp_top.sv
// top level: word store, cost memories and the backward line break sequencer
// load of a word: accepted while idle; the paragraph's last word starts the solve
// solve: per word the fixed cost (widow and orphan divides) and its write back,
//   plus one pass per break candidate over the shared read address of the memories
// then the chosen breaks are followed to count lines; a line read uses ST_RREAD
// reset (rst, synchronous) sets config, state and paragraph; stores are not cleared
`timescale 1ns / 1ps
module optimal_line_break_dp_top
  import olb_pkg::*;
#(
  parameter int MAX_WORDS = 1024,
  parameter int COST_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   command,
  input  logic [WW-1:0]          word_width,
  input  logic [SPW-1:0]         space_after,
  input  logic                   opens_paren,
  input  logic                   ends_period,
  input  logic                   ends_punct,
  input  logic                   ends_sentence,
  input  logic                   last_word,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             status,
  output logic [IDX_OUT_W-1:0]   line_start,
  output logic [IDX_OUT_W-1:0]   line_end,
  output logic [COL_W-1:0]       line_columns,
  output logic [IDX_OUT_W-1:0]   line_total,
  output logic signed [COST_OUT_W-1:0] total_cost,
  output logic                   final_line,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_WORDS);        // word store address
  localparam int IW = $clog2(MAX_WORDS + 1);    // word index incl. the end
  localparam int CDEPTH = MAX_WORDS + 1;
  localparam logic signed [COST_BITS-1:0] COST_MAX = {1'b0, {(COST_BITS-1){1'b1}}};
  localparam logic signed [COST_BITS-1:0] COST_MIN = {1'b1, {(COST_BITS-1){1'b0}}};

  typedef enum logic [19:0] {
    ST_IDLE  = 20'h00001,
    ST_RREAD = 20'h00002,
    ST_EMIT  = 20'h00004,
    ST_SINIT = 20'h00008,
    ST_FA    = 20'h00010,
    ST_FB    = 20'h00020,
    ST_FC    = 20'h00040,
    ST_FD    = 20'h00080,
    ST_FW    = 20'h00100,
    ST_FO    = 20'h00200,
    ST_CA    = 20'h00400,
    ST_CB    = 20'h00800,
    ST_M1    = 20'h01000,
    ST_M2    = 20'h02000,
    ST_M3    = 20'h04000,
    ST_S1    = 20'h08000,
    ST_S2    = 20'h10000,
    ST_SEND  = 20'h20000,
    ST_LA    = 20'h40000,
    ST_LB    = 20'h80000
  } state_t;

  function automatic logic signed [COST_BITS-1:0] sat_add(
    input logic signed [COST_BITS-1:0] a,
    input logic signed [COST_BITS-1:0] b
  );
    logic signed [COST_BITS:0] sum;
    sum = {a[COST_BITS-1], a} + {b[COST_BITS-1], b};
    if (sum[COST_BITS] != sum[COST_BITS-1]) begin
      return sum[COST_BITS] ? COST_MIN : COST_MAX;
    end
    return sum[COST_BITS-1:0];
  endfunction

  state_t state;

  // configuration registers
  logic [CFG_W-1:0]  line_limit, line_goal, first_ind, other_ind;
  logic [PREV_W-1:0] prev_width;

  // paragraph bookkeeping
  logic [IW-1:0] count, rp, n, s, w, p, lines;
  logic          solved;
  logic [IW-1:0] eff_count;

  // per-start registers
  logic [MARK_W-1:0] mark_t, mark_p;
  logic [WW-1:0]     width_t, width_p;
  logic [SPW-1:0]    space_t, space_prev;
  logic signed [FIX_W-1:0] fixed, fix_base;
  logic widow_en, orphan_en, widow_c, orphan_c;
  logic [WID_W-1:0]  wid, wid_next;
  logic signed [COST_BITS-1:0] best, total, wc1, wc, send_cost;
  logic              have;
  logic [IW-1:0]     brk_s;
  logic [COL_W-1:0]  cw_s;

  // per-candidate registers
  logic signed [COST_BITS-1:0] best_w;
  logic [IW-1:0]     brk_w;
  logic [WW-1:0]     width_w;
  logic [SPW-1:0]    space_w;
  logic signed [DIFF_W-1:0] d_goal, d_next, d_prev, sq_d;
  logic [SQ_W-1:0]   sq_q, sq1, sq2, sq3;
  logic [FIT_W-1:0]  fit;

  // memories
  word_t                        word_mem [MAX_WORDS];
  logic signed [COST_BITS-1:0]  cost_mem [CDEPTH];
  logic [IW-1:0]                brk_mem  [MAX_WORDS];
  logic [COL_W-1:0]             cw_mem   [MAX_WORDS];
  word_t                        word_q;
  logic signed [COST_BITS-1:0]  cost_q;
  logic [IW-1:0]                brk_q;
  logic [COL_W-1:0]             cw_q;
  logic [IW-1:0]                rd_addr;
  logic                         word_we, cost_we, res_we;
  logic [IW-1:0]                cost_waddr;
  logic signed [COST_BITS-1:0]  cost_wdata;
  word_t                        word_in;

  // divider
  div_req_t          div_req;
  logic              div_busy;
  logic [DIV_W-1:0]  div_quot;

  res_t res, out_q;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign eff_count = solved ? '0 : count;

  olb_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .quot (div_quot)
  );

  olb_sq u_sq (
    .clk (clk),
    .d   (sq_d),
    .sq  (sq_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= CFG_W'(75);
      line_goal  <= CFG_W'(70);
      first_ind  <= '0;
      other_ind  <= '0;
      prev_width <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_WIDTH:  line_limit <= cfg_data[CFG_W-1:0];
        CFG_GOAL_WIDTH: line_goal  <= cfg_data[CFG_W-1:0];
        CFG_FIRST_IND:  first_ind  <= cfg_data[CFG_W-1:0];
        CFG_OTHER_IND:  other_ind  <= cfg_data[CFG_W-1:0];
        CFG_PREV_WIDTH: prev_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // incoming word with the last word forced to a sentence end
  always_comb begin
    word_in.width = word_width;
    word_in.space = space_after;
    word_in.mark  = {ends_sentence | last_word, ends_punct,
                     ends_period | last_word, opens_paren};
  end

  // shared read address for all stores
  always_comb begin
    case (state)
      ST_FA:   rd_addr = s;
      ST_FB:   rd_addr = s - 1'b1;
      ST_FC:   rd_addr = s - IW'(2);
      ST_CA:   rd_addr = w + 1'b1;
      ST_LA:   rd_addr = p;
      default: rd_addr = rp;
    endcase
  end

  assign word_we = (state == ST_IDLE) && in_valid && (command == CMD_LOAD) &&
                   (eff_count < IW'(MAX_WORDS));

  // fixed cost before the widow and orphan divides
  always_comb begin
    fix_base = FIX_W'(C_LINE);
    widow_c  = 1'b0;
    if (s != '0) begin
      if (mark_p[MK_PERIOD]) begin
        fix_base = mark_p[MK_FINAL] ? fix_base - FIX_W'(C_SENTENCE)
                                    : fix_base + FIX_W'(C_NOBREAK);
      end else if (mark_p[MK_PUNCT]) begin
        fix_base = fix_base - FIX_W'(C_PUNCT);
      end else begin
        widow_c = (s > IW'(1)) && word_q.mark[MK_FINAL];
      end
    end
    orphan_c = 1'b0;
    if (mark_t[MK_PAREN]) begin
      fix_base = fix_base - FIX_W'(C_PAREN);
    end else begin
      orphan_c = mark_t[MK_FINAL];
    end
  end

  always_comb begin
    div_req.start = (state == ST_FD) || ((state == ST_FW) && !div_busy);
    div_req.num   = (state == ST_FD) ? DIV_W'(C_WIDOW) : DIV_W'(C_ORPHAN);
    div_req.den   = (state == ST_FD) ? DEN_W'(width_p) + DEN_W'(2)
                                     : DEN_W'(width_t) + DEN_W'(2);
  end

  always_comb begin
    case (state)
      ST_M2:   sq_d = d_next;
      ST_M3:   sq_d = d_prev;
      default: sq_d = d_goal;
    endcase
  end

  // candidate cost: short cost, ragged cost to the next and prior lines, best tail
  always_comb begin
    fit = FIT_W'(sq1) + ((brk_w != n) ? FIT_W'(sq2 >> 1) : '0);
    if (w >= n) begin
      fit = '0;
    end
    wc = wc1;
    if ((s == '0) && (prev_width != '0)) begin
      wc = sat_add(wc1, COST_BITS'(sq3 >> 1));
    end
    wid_next  = wid + WID_W'(space_prev) + WID_W'(width_w);
    send_cost = sat_add(best, COST_BITS'(fixed));
  end

  assign cost_we    = (state == ST_SINIT) || (state == ST_SEND);
  assign cost_waddr = (state == ST_SINIT) ? n : s;
  assign cost_wdata = (state == ST_SINIT) ? '0 : send_cost;
  assign res_we     = (state == ST_SEND);

  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[eff_count[AW-1:0]] <= word_in;
    end
    word_q <= word_mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
    cost_q <= cost_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      brk_mem[s[AW-1:0]] <= brk_s;
      cw_mem[s[AW-1:0]]  <= cw_s;
    end
    brk_q <= brk_mem[rd_addr[AW-1:0]];
    cw_q  <= cw_mem[rd_addr[AW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      rp     <= '0;
      solved <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (command == CMD_LOAD) begin
              solved <= 1'b0;
              if (solved) begin
                rp <= '0;
              end
              if (eff_count >= IW'(MAX_WORDS)) begin
                // paragraph too long: drop it
                count <= '0;
                rp    <= '0;
                res   <= '{status: STAT_REJECT, default: '0};
                state <= ST_EMIT;
              end else begin
                count <= eff_count + 1'b1;
                if (last_word) begin
                  n     <= eff_count + 1'b1;
                  state <= ST_SINIT;
                end
              end
            end else if (!solved || rp >= count) begin
              res   <= '{status: STAT_REJECT, default: '0};
              state <= ST_EMIT;
            end else begin
              state <= ST_RREAD;
            end
          end
        end
        ST_RREAD: begin
          res   <= '{status: STAT_LINE, line_start: IDX_OUT_W'(rp),
                     line_end: IDX_OUT_W'(brk_q), line_columns: cw_q,
                     final_line: (brk_q >= count), default: '0};
          rp    <= brk_q;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_SINIT: begin
          s     <= n - 1'b1;
          state <= ST_FA;
        end
        ST_FA: state <= ST_FB;
        ST_FB: begin
          mark_t  <= word_q.mark;
          width_t <= word_q.width;
          space_t <= word_q.space;
          state   <= ST_FC;
        end
        ST_FC: begin
          mark_p  <= word_q.mark;
          width_p <= word_q.width;
          state   <= ST_FD;
        end
        ST_FD: begin
          fixed     <= fix_base;
          widow_en  <= widow_c;
          orphan_en <= orphan_c;
          state     <= ST_FW;
        end
        ST_FW: begin
          if (!div_busy) begin
            if (widow_en) begin
              fixed <= fixed + FIX_W'(div_quot);
            end
            state <= ST_FO;
          end
        end
        ST_FO: begin
          if (!div_busy) begin
            if (orphan_en) begin
              fixed <= fixed + FIX_W'(div_quot);
            end
            wid        <= WID_W'((s == '0) ? first_ind : other_ind) + WID_W'(width_t);
            w          <= s;
            have       <= 1'b0;
            best       <= COST_MAX;
            space_prev <= space_t;
            state      <= ST_CA;
          end
        end
        ST_CA: begin
          w     <= w + 1'b1;
          state <= ST_CB;
        end
        ST_CB: begin
          best_w  <= cost_q;
          brk_w   <= brk_q;
          width_w <= word_q.width;
          space_w <= word_q.space;
          d_goal  <= DIFF_W'(line_goal) - DIFF_W'(wid);
          d_next  <= DIFF_W'(wid) - DIFF_W'(cw_q);
          d_prev  <= DIFF_W'(wid) - DIFF_W'(prev_width);
          state   <= ST_M1;
        end
        ST_M1: state <= ST_M2;
        ST_M2: begin
          sq1   <= sq_q;
          state <= ST_M3;
        end
        ST_M3: begin
          sq2   <= sq_q;
          state <= ST_S1;
        end
        ST_S1: begin
          sq3   <= sq_q;
          wc1   <= sat_add(COST_BITS'(fit), best_w);
          state <= ST_S2;
        end
        ST_S2: begin
          // first candidate always taken, later ones only if strictly cheaper
          if (!have || wc < best) begin
            have  <= 1'b1;
            best  <= wc;
            brk_s <= w;
            cw_s  <= (wid[WID_W-1:COL_W] != '0) ? {COL_W{1'b1}} : wid[COL_W-1:0];
          end
          if (w >= n) begin
            state <= ST_SEND;
          end else begin
            wid        <= wid_next;
            space_prev <= space_w;
            state      <= (wid_next < WID_W'(line_limit)) ? ST_CA : ST_SEND;
          end
        end
        ST_SEND: begin
          if (s == '0) begin
            total <= send_cost;
            p     <= '0;
            lines <= '0;
            state <= ST_LA;
          end else begin
            s     <= s - 1'b1;
            state <= ST_FA;
          end
        end
        ST_LA: begin
          if (p >= n) begin
            res    <= '{status: STAT_SUMMARY, line_end: IDX_OUT_W'(n),
                        line_total: IDX_OUT_W'(lines),
                        total_cost: COST_OUT_W'(64'(total)), default: '0};
            solved <= 1'b1;
            rp     <= '0;
            state  <= ST_EMIT;
          end else begin
            state <= ST_LB;
          end
        end
        ST_LB: begin
          p     <= brk_q;
          lines <= lines + 1'b1;
          state <= ST_LA;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register: takes a result when empty or while the previous beat leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      out_valid <= 1'b1;
      out_q     <= res;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status       = out_q.status;
  assign line_start   = out_q.line_start;
  assign line_end     = out_q.line_end;
  assign line_columns = out_q.line_columns;
  assign line_total   = out_q.line_total;
  assign total_cost   = out_q.total_cost;
  assign final_line   = out_q.final_line;

  // word count never passes the store depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= IW'(MAX_WORDS))
    else $error("word count beyond store depth");

  // a solved paragraph holds at least one word and the read point stays inside it
  a_solved_rp: assert property (@(posedge clk) disable iff (rst)
    solved |-> (count != '0) && (rp <= count))
    else $error("read position outside solved paragraph");

  // every chosen break lies strictly after its line start
  a_break_ahead: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND) |-> (brk_s > s) && (brk_s <= n))
    else $error("chosen break not ahead of line start");

  // candidate index stays within the paragraph while solving
  a_cand_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CB) |-> (w > s) && (w <= n))
    else $error("candidate index out of range");

  // a result is only offered once the sequencer hands one over
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("result beat without emit");

endmodule

### verif/optimal_line_break_dp_top_test.sv
// self-checking testbench for the optimal line break engine
`timescale 1ns / 1ps
module optimal_line_break_dp_top_test;
  import olb_pkg::*;

  localparam int NWORDS = 1024;
  localparam longint CMAX = (longint'(1) <<< 47) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam int QUIET_CYC = 64;     // idle time before a register write
  localparam int HOLD_CYC = 400;     // long receiver hold-off
  localparam int HOLD_AT = 24;       // result count at the summary of the pressure paragraph

  // kinds of entries in the stimulus queue
  typedef enum logic [1:0] {K_WORD, K_READ, K_CFG, K_DRAIN} pend_kind_t;

  typedef struct {
    pend_kind_t             kind;
    logic [WW-1:0]          width;
    logic [SPW-1:0]         space;
    logic [3:0]             marks;   // paren, period, punct, sentence
    logic                   last;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
  } pend_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  command = CMD_LOAD;
  logic [WW-1:0]         word_width = '0;
  logic [SPW-1:0]        space_after = '0;
  logic                  opens_paren = 1'b0;
  logic                  ends_period = 1'b0;
  logic                  ends_punct = 1'b0;
  logic                  ends_sentence = 1'b0;
  logic                  last_word = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  logic [1:0]            status;
  logic [IDX_OUT_W-1:0]  line_start;
  logic [IDX_OUT_W-1:0]  line_end;
  logic [COL_W-1:0]      line_columns;
  logic [IDX_OUT_W-1:0]  line_total;
  logic signed [COST_OUT_W-1:0] total_cost;
  logic                  final_line;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  optimal_line_break_dp_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .word_width(word_width), .space_after(space_after), .opens_paren(opens_paren),
    .ends_period(ends_period), .ends_punct(ends_punct), .ends_sentence(ends_sentence),
    .last_word(last_word),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .line_start(line_start), .line_end(line_end), .line_columns(line_columns),
    .line_total(line_total), .total_cost(total_cost), .final_line(final_line),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // line break predictor: own copy of registers and paragraph state
  // ---------------------------------------------------------------------------
  int unsigned lim_width, tgt_width, ind_first, ind_other, prior_width;
  logic [11:0] wd_mem [NWORDS+1];
  logic [11:0] sp_mem [NWORDS+1];
  logic [3:0]  mk_mem [NWORDS+1];   // bit0 paren, bit1 period, bit2 punct, bit3 sentence
  longint      cost_mem [NWORDS+1];
  int          brk_mem [NWORDS+1];
  int          colw_mem [NWORDS+1];
  int          word_cnt, read_pos;
  bit          para_done;

  pend_t pend_q [$];
  res_t  line_exp_q [$];
  int    n_fail, n_results, n_paras, n_lines, n_rejects, n_items;

  function automatic longint clamp_cost(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    if (b > 0 && a > CMAX - b) return CMAX;
    if (b < 0 && a < CMIN - b) return CMIN;
    return a + b;
  endfunction

  function automatic longint short_pen(longint n);
    longint t;
    t = n * 10;
    return clamp_cost(t * t);
  endfunction

  function automatic longint ragged_pen(longint n);
    return short_pen(n) / 2;
  endfunction

  // shortness against goal plus raggedness against the following line
  function automatic longint fit_pen(int nx, longint wid, int n);
    longint c;
    if (nx >= n) return 0;
    c = short_pen(longint'(tgt_width) - wid);
    if (brk_mem[nx] != n) c = add_sat(c, ragged_pen(wid - longint'(colw_mem[nx])));
    return c;
  endfunction

  // per-line cost of a line starting at word t
  function automatic longint line_pen(int t);
    longint c;
    logic [3:0] pm;
    c = C_LINE;
    if (t > 0) begin
      pm = mk_mem[t-1];
      if (pm[1]) c += pm[3] ? -C_SENTENCE : C_NOBREAK;
      else if (pm[2]) c -= C_PUNCT;
      else if (t > 1 && mk_mem[t-2][3]) c += C_WIDOW / (longint'(wd_mem[t-1]) + 2);
    end
    if (mk_mem[t][0]) c -= C_PAREN;
    else if (mk_mem[t][3]) c += C_ORPHAN / (longint'(wd_mem[t]) + 2);
    return clamp_cost(c);
  endfunction

  // backward minimum-cost pass over the loaded paragraph
  task automatic solve_breaks(int n);
    longint wid, best, wc;
    bit have;
    int w;
    cost_mem[n] = 0;
    for (int s = n - 1; s >= 0; s--) begin
      wid = longint'(s == 0 ? ind_first : ind_other) + wd_mem[s];
      best = CMAX;
      have = 0;
      w = s;
      forever begin
        w++;
        wc = add_sat(fit_pen(w, wid, n), cost_mem[w]);
        if (s == 0 && prior_width > 0) wc = add_sat(wc, ragged_pen(wid - prior_width));
        // first candidate always taken, later ones only if strictly cheaper
        if (!have || wc < best) begin
          have = 1;
          best = wc;
          brk_mem[s] = w;
          colw_mem[s] = wid > 16383 ? 16383 : int'(wid);
        end
        if (w >= n) break;
        wid += longint'(sp_mem[w-1]) + wd_mem[w];
        if (!(wid < longint'(lim_width))) break;
      end
      cost_mem[s] = add_sat(best, line_pen(s));
    end
  endtask

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_MAX_WIDTH:  lim_width = d[11:0];
      CFG_GOAL_WIDTH: tgt_width = d[11:0];
      CFG_FIRST_IND:  ind_first = d[11:0];
      CFG_OTHER_IND:  ind_other = d[11:0];
      CFG_PREV_WIDTH: prior_width = d[13:0];
      default: ;
    endcase
  endtask

  // expected results of one accepted beat on the input channel
  task automatic predict_beat(pend_t p);
    res_t r;
    int n, pos, cnt;
    r = '0;
    if (p.kind == K_WORD) begin
      if (para_done) begin
        para_done = 0;
        word_cnt = 0;
        read_pos = 0;
      end
      if (word_cnt >= NWORDS) begin
        // overflow drops the word and the whole paragraph
        word_cnt = 0;
        read_pos = 0;
        r.status = STAT_REJECT;
        line_exp_q.push_back(r);
        return;
      end
      wd_mem[word_cnt] = p.width;
      sp_mem[word_cnt] = p.space;
      mk_mem[word_cnt] = p.last ? (p.marks | 4'b1010) : p.marks;
      word_cnt++;
      if (!p.last) return;
      n = word_cnt;
      solve_breaks(n);
      pos = 0;
      cnt = 0;
      while (pos < n) begin
        pos = brk_mem[pos];
        cnt++;
      end
      para_done = 1;
      read_pos = 0;
      r.status = STAT_SUMMARY;
      r.line_end = n[10:0];
      r.line_total = cnt[10:0];
      r.total_cost = cost_mem[0][47:0];
      line_exp_q.push_back(r);
      return;
    end
    if (!para_done || read_pos >= word_cnt) begin
      r.status = STAT_REJECT;
    end else begin
      r.status = STAT_LINE;
      r.line_start = read_pos[10:0];
      r.line_end = brk_mem[read_pos][10:0];
      r.line_columns = colw_mem[read_pos][13:0];
      r.final_line = brk_mem[read_pos] >= word_cnt;
      read_pos = brk_mem[read_pos];
    end
    line_exp_q.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_word(int wd, int sp, logic [3:0] mk, logic last);
    pend_t p;
    p = '{kind: K_WORD, width: WW'(wd), space: SPW'(sp), marks: mk, last: last,
          idx: '0, data: '0};
    pend_q.push_back(p);
  endtask

  task automatic add_read();
    pend_t p;
    p = '{kind: K_READ, width: WW'($urandom), space: SPW'($urandom), marks: 4'($urandom),
          last: 1'($urandom), idx: '0, data: '0};
    pend_q.push_back(p);
  endtask

  task automatic add_reg(logic [CFG_IDX_W-1:0] idx, int d);
    pend_t p;
    p = '{kind: K_CFG, width: '0, space: '0, marks: '0, last: 1'b0, idx: idx,
          data: CFG_DATA_W'(d)};
    pend_q.push_back(p);
  endtask

  task automatic add_drain();
    pend_t p;
    p = '{kind: K_DRAIN, width: '0, space: '0, marks: '0, last: 1'b0, idx: '0, data: '0};
    pend_q.push_back(p);
  endtask

  task automatic set_regs(int mw, int gw, int fi, int oi, int pw);
    add_reg(CFG_MAX_WIDTH, mw);
    add_reg(CFG_GOAL_WIDTH, gw);
    add_reg(CFG_FIRST_IND, fi);
    add_reg(CFG_OTHER_IND, oi);
    add_reg(CFG_PREV_WIDTH, pw);
  endtask

  // random paragraph followed by some reads, sometimes with noise inside
  task automatic add_paragraph(int nmax);
    int n, wd, sp, k;
    n = $urandom_range(1, nmax);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      wd = (k == 0) ? $urandom_range(0, 4095) : (k == 1) ? 0 : $urandom_range(1, 12);
      sp = (k == 2) ? $urandom_range(0, 4095) : $urandom_range(0, 2);
      if ($urandom_range(0, 29) == 0) add_read();   // read while still loading
      add_word(wd, sp, 4'($urandom), i == n - 1);
    end
    k = $urandom_range(0, n + 2);
    for (int i = 0; i < k; i++) add_read();
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued beats and register writes
  // ---------------------------------------------------------------------------
  int drv_gap, quiet_cnt;
  bit calm;

  always @(posedge clk) begin : drv
    logic v_next, c_next;
    pend_t h;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      drv_gap = 0;
      quiet_cnt = 0;
    end else begin
      v_next = in_valid;
      c_next = cfg_valid;
      if (in_valid && !in_stall) begin
        h.kind = command == CMD_READ ? K_READ : K_WORD;
        h.width = word_width;
        h.space = space_after;
        h.marks = {ends_sentence, ends_punct, ends_period, opens_paren};
        h.last = last_word;
        predict_beat(h);
        n_items++;
        v_next = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        c_next = 1'b0;
      end
      if (line_exp_q.size() == 0 && !in_valid) quiet_cnt++;
      else quiet_cnt = 0;
      if (!v_next && !c_next && pend_q.size() > 0) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else begin
          h = pend_q[0];
          case (h.kind)
            K_WORD, K_READ: begin
              command <= h.kind == K_READ ? CMD_READ : CMD_LOAD;
              word_width <= h.width;
              space_after <= h.space;
              {ends_sentence, ends_punct, ends_period, opens_paren} <= h.marks;
              last_word <= h.last;
              v_next = 1'b1;
              void'(pend_q.pop_front());
              drv_gap = calm ? 0 : $urandom_range(0, 4);
            end
            K_CFG: begin
              // registers change only with the engine idle
              if (quiet_cnt >= QUIET_CYC) begin
                cfg_index <= h.idx;
                cfg_data <= h.data;
                c_next = 1'b1;
                void'(pend_q.pop_front());
              end
            end
            default: begin
              if (line_exp_q.size() == 0) void'(pend_q.pop_front());
            end
          endcase
        end
      end
      in_valid <= v_next;
      cfg_valid <= c_next;
    end
  end

  // ---------------------------------------------------------------------------
  // long receiver hold-off, counted here so the engine backs up into its input
  // ---------------------------------------------------------------------------
  bit hold_on;

  initial begin : hold_proc
    hold_on = 1'b0;
    wait (n_results >= HOLD_AT);
    hold_on = 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    hold_on = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // monitor: random receiver stalls, field checks
  // ---------------------------------------------------------------------------
  int mon_wait;

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin : mon
    res_t e;
    if (rst) begin
      out_stall <= 1'b1;
      mon_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (line_exp_q.size() == 0) begin
          $display("%0t unexpected result beat: status %0d", $time, status);
          n_fail++;
        end else begin
          e = line_exp_q.pop_front();
          check_field("status", e.status, status);
          check_field("line_start", e.line_start, line_start);
          check_field("line_end", e.line_end, line_end);
          check_field("line_columns", e.line_columns, line_columns);
          check_field("line_total", e.line_total, line_total);
          check_field("total_cost", longint'($signed(e.total_cost)), longint'(total_cost));
          check_field("final_line", e.final_line, final_line);
          case (e.status)
            STAT_SUMMARY: n_paras++;
            STAT_LINE:    n_lines++;
            default:      n_rejects++;
          endcase
        end
        mon_wait = calm ? 0 : $urandom_range(0, 4);
      end else if (mon_wait > 0) begin
        mon_wait--;
      end
      out_stall <= (mon_wait > 0) || hold_on;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    lim_width = 75; tgt_width = 70; ind_first = 0; ind_other = 0; prior_width = 0;
    word_cnt = 0; read_pos = 0; para_done = 0;
    n_fail = 0; n_results = 0; n_paras = 0; n_lines = 0; n_rejects = 0; n_items = 0;
    calm = 0;

    // directed: read before any paragraph, then reset settings
    add_read();
    // single word paragraph, then reads of its only line and past it
    add_word(5, 1, 4'b0000, 1'b1);
    add_read();
    add_read();
    // field extremes and every mark
    add_word(4095, 4095, 4'b1111, 1'b0);
    add_word(0, 0, 4'b0001, 1'b0);
    add_word(3, 1, 4'b0010, 1'b0);     // period without sentence end: no-break cost
    add_word(4, 1, 4'b0100, 1'b0);     // punctuation bonus
    add_word(2, 1, 4'b1000, 1'b0);     // sentence end: widow after it
    add_word(6, 1, 4'b0000, 1'b0);
    add_word(1, 0, 4'b0000, 1'b1);
    repeat (8) add_read();
    add_drain();
    // nonzero prior width and indents
    set_regs(40, 30, 4095, 4095, 16383);
    add_word(10, 1, 4'b0001, 1'b0);
    add_word(10, 1, 4'b0000, 1'b1);
    repeat (3) add_read();
    add_drain();
    set_regs(75, 70, 0, 0, 0);

    // overflow: the word past the store depth discards the paragraph
    for (int i = 0; i <= NWORDS; i++) add_word($urandom_range(1, 8), 1, 4'($urandom), 1'b0);
    add_read();
    add_word(7, 1, 4'b0000, 1'b1);
    repeat (3) add_read();
    add_drain();

    // pressure: the receiver holds off after this summary while reads keep coming
    for (int i = 0; i < 20; i++) add_word($urandom_range(1, 8), 1, 4'($urandom), i == 19);
    repeat (24) add_read();
    add_drain();

    // random phases over several register settings
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: set_regs(75, 70, 0, 0, 0);
        1: set_regs(0, 0, 0, 0, 0);
        2: set_regs(2500, 2500, 0, 0, 16383);
        3: set_regs(2500, 0, 4095, 0, 0);
        4: set_regs(20, 2500, 0, 4095, 1);
        default: set_regs($urandom_range(0, 2500), $urandom_range(0, 2500),
                          $urandom_range(0, 4095) & ($urandom_range(0, 1) ? 12'hfff : 12'h00f),
                          $urandom_range(0, 4095) & ($urandom_range(0, 1) ? 12'hfff : 12'h00f),
                          $urandom_range(0, 16383));
      endcase
      add_paragraph(12);
      add_drain();   // sender waits for every result
    end
    // short burst with no idling on either side
    wait (pend_q.size() < 40);
    calm = 1;
    repeat (2) add_paragraph(8);
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (calm && pend_q.size() == 0);
    wait (!in_valid && line_exp_q.size() == 0);
    repeat (200) @(posedge clk);
    if (line_exp_q.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, line_exp_q.size());
      n_fail++;
    end
    $display("run covered %0d input beats: %0d paragraphs, %0d lines, %0d rejects",
             n_items, n_paras, n_lines, n_rejects);
    $display("register settings swept including extremes, %0d mismatches", n_fail);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("%0t timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
